/* hdl/session_id_table_unit_defines.svh */
// Assertion helpers used by the checker module.
`ifndef SESSION_ID_TABLE_UNIT_DEFINES_SVH
`define SESSION_ID_TABLE_UNIT_DEFINES_SVH

// Checked on every rising edge outside reset.
`define STID_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define STID_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* hdl/stid_pkg.sv */
package stid_pkg;

    // Table size and derived widths
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int ID_W        = 31;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((2 * ID_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ID_W + COUNT_OUT_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD      = 2'd0,
        FUNC_FIND_EXT = 2'd1,
        FUNC_FIND_SES = 2'd2,
        FUNC_REMOVE   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    // One table entry
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] ext;
        logic [ID_W-1:0] ses;
    } entry_t;

    // Control from the sequencer to the cell chain
    typedef struct packed {
        logic   shift;
        logic   wr_en;
        entry_t wr_entry;
    } chain_ctl_t;

endpackage

/* hdl/session_id_table_unit.sv */
// Channel | Dir | tdata (low bit up)                 | tuser
// s_*     | in  | external_key[30:0], session_key[61:31], zero pad | func[1:0]
// m_*     | out | found_id[30:0], entry_count[37:31], zero pad     | status[1:0]
//
// One item at a time. The table rotates once through the cell ring per
// item, in the steps accept, scan, decide and result; lookups and refused
// operations stop there. A successful add or remove rotates the ring a
// second time, between decide and result, to place its write.
// Reset clears every valid bit, the session counter and the entry count.
// A stalled result holds in the output register; the next item is taken
// while it waits, and its result waits until the register is free.
module session_id_table_unit import stid_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // external_key, session_key
    input  logic [FUNC_W-1:0]    s_tuser,  // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // found_id, entry_count
    output logic [STATUS_W-1:0]  m_tuser   // status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_APPLY,
        S_DONE
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] pos_reg;

    // Latched item
    func_t           func_reg;
    logic [ID_W-1:0] key_ext_reg;
    logic [ID_W-1:0] key_ses_reg;

    // Scan results
    logic             ext_hit_reg;
    logic [ID_W-1:0]  ext_ses_reg;
    logic             ses_hit_reg;
    logic [IDX_W-1:0] ses_slot_reg;
    logic [ID_W-1:0]  ses_ext_reg;
    logic             free_hit_reg;
    logic [IDX_W-1:0] free_slot_reg;

    // Pending write
    logic [IDX_W-1:0] wr_slot_reg;
    entry_t           wr_entry_reg;

    // Table counters
    logic [ID_W-1:0]  next_ses_reg;
    logic [CNT_W-1:0] count_reg;

    // Result of the current item and the output register
    status_t          res_status_reg;
    logic [ID_W-1:0]  res_id_reg;
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [ID_W-1:0]  out_id_reg;
    logic [CNT_W-1:0] out_count_reg;

    chain_ctl_t ctl;
    entry_t     head;
    logic       ext_match;
    logic       ses_match;
    logic       pos_last;

    stid_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .head  (head)
    );

    // Compare at the head of the ring
    assign ext_match = head.valid && (head.ext == key_ext_reg);
    assign ses_match = head.valid && (head.ses == key_ses_reg);
    assign pos_last  = (pos_reg == IDX_W'(CAPACITY - 1));

    // Ring control
    assign ctl.shift    = (state_reg == S_SCAN) || (state_reg == S_APPLY);
    assign ctl.wr_en    = (state_reg == S_APPLY) && (pos_reg == wr_slot_reg);
    assign ctl.wr_entry = wr_entry_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            func_reg       <= FUNC_ADD;
            key_ext_reg    <= '0;
            key_ses_reg    <= '0;
            ext_hit_reg    <= 1'b0;
            ext_ses_reg    <= '0;
            ses_hit_reg    <= 1'b0;
            ses_slot_reg   <= '0;
            ses_ext_reg    <= '0;
            free_hit_reg   <= 1'b0;
            free_slot_reg  <= '0;
            wr_slot_reg    <= '0;
            wr_entry_reg   <= '0;
            next_ses_reg   <= '0;
            count_reg      <= '0;
            res_status_reg <= STAT_MISS;
            res_id_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_MISS;
            out_id_reg     <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            // Result taken; S_DONE reloads the register itself
            if (out_valid_reg && m_tready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        func_reg     <= func_t'(s_tuser);
                        key_ext_reg  <= s_tdata[ID_W-1:0];
                        key_ses_reg  <= s_tdata[2*ID_W-1:ID_W];
                        ext_hit_reg  <= 1'b0;
                        ses_hit_reg  <= 1'b0;
                        free_hit_reg <= 1'b0;
                        pos_reg      <= '0;
                        state_reg    <= S_SCAN;
                    end
                end

                // Walk the ring in slot order; keep the lowest hit of each kind
                S_SCAN:
                begin
                    if (ext_match && !ext_hit_reg)
                    begin
                        ext_hit_reg <= 1'b1;
                        ext_ses_reg <= head.ses;
                    end
                    if (ses_match && !ses_hit_reg)
                    begin
                        ses_hit_reg  <= 1'b1;
                        ses_slot_reg <= pos_reg;
                        ses_ext_reg  <= head.ext;
                    end
                    if (!head.valid && !free_hit_reg)
                    begin
                        free_hit_reg  <= 1'b1;
                        free_slot_reg <= pos_reg;
                    end
                    if (pos_last)
                    begin
                        pos_reg   <= '0;
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end

                S_DECIDE:
                begin
                    case (func_reg)
                        FUNC_ADD:
                        begin
                            if (ext_hit_reg)
                            begin
                                res_status_reg <= STAT_MISS;
                                res_id_reg     <= '0;
                                state_reg      <= S_DONE;
                            end
                            else if (!free_hit_reg)
                            begin
                                res_status_reg <= STAT_FULL;
                                res_id_reg     <= '0;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                res_status_reg     <= STAT_OK;
                                res_id_reg         <= next_ses_reg;
                                wr_slot_reg        <= free_slot_reg;
                                wr_entry_reg.valid <= 1'b1;
                                wr_entry_reg.ext   <= key_ext_reg;
                                wr_entry_reg.ses   <= next_ses_reg;
                                next_ses_reg       <= next_ses_reg + 1'b1;
                                count_reg          <= count_reg + 1'b1;
                                state_reg          <= S_APPLY;
                            end
                        end
                        FUNC_FIND_EXT:
                        begin
                            state_reg <= S_DONE;
                            if (ext_hit_reg)
                            begin
                                res_status_reg <= STAT_OK;
                                res_id_reg     <= ext_ses_reg;
                            end
                            else
                            begin
                                res_status_reg <= STAT_MISS;
                                res_id_reg     <= '0;
                            end
                        end
                        FUNC_FIND_SES:
                        begin
                            state_reg <= S_DONE;
                            if (ses_hit_reg)
                            begin
                                res_status_reg <= STAT_OK;
                                res_id_reg     <= ses_ext_reg;
                            end
                            else
                            begin
                                res_status_reg <= STAT_MISS;
                                res_id_reg     <= '0;
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            if (ses_hit_reg)
                            begin
                                res_status_reg     <= STAT_OK;
                                res_id_reg         <= key_ses_reg;
                                wr_slot_reg        <= ses_slot_reg;
                                wr_entry_reg.valid <= 1'b0;
                                wr_entry_reg.ext   <= ses_ext_reg;
                                wr_entry_reg.ses   <= key_ses_reg;
                                if (count_reg != '0)
                                begin
                                    count_reg <= count_reg - 1'b1;
                                end
                                state_reg <= S_APPLY;
                            end
                            else
                            begin
                                res_status_reg <= STAT_MISS;
                                res_id_reg     <= '0;
                                state_reg      <= S_DONE;
                            end
                        end
                        default:
                        begin
                            res_status_reg <= STAT_MISS;
                            res_id_reg     <= '0;
                            state_reg      <= S_DONE;
                        end
                    endcase
                end

                // Second rotation; the write replaces the target slot in passing
                S_APPLY:
                begin
                    if (pos_last)
                    begin
                        pos_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_id_reg     <= res_id_reg;
                        out_count_reg  <= count_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_TDATA_W - ID_W - COUNT_OUT_W){1'b0}},
                       COUNT_OUT_W'(out_count_reg), out_id_reg};

endmodule

/* hdl/stid_cell.sv */
module stid_cell import stid_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift,
    input  entry_t din,
    output entry_t dout
);

    logic            valid_reg;
    logic [ID_W-1:0] ext_reg;
    logic [ID_W-1:0] ses_reg;

    // Valid bit: cleared by reset, loaded from the neighbor on shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= din.valid;
        end
    end

    // Ids: only meaningful while valid
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            ext_reg <= din.ext;
            ses_reg <= din.ses;
        end
    end

    assign dout.valid = valid_reg;
    assign dout.ext   = ext_reg;
    assign dout.ses   = ses_reg;

endmodule

/* hdl/stid_chain.sv */
module stid_chain import stid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  chain_ctl_t ctl,
    output entry_t     head
);

    entry_t cell_out [CAPACITY];
    entry_t cell_in  [CAPACITY];

    // Ring of cells: each takes its upper neighbor, the last one takes the
    // head back, or the replacement entry when a write lands on this pass.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == CAPACITY - 1)
        begin : g_tail
            assign cell_in[i] = ctl.wr_en ? ctl.wr_entry : cell_out[0];
        end
        else
        begin : g_body
            assign cell_in[i] = cell_out[i + 1];
        end

        stid_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (ctl.shift),
            .din   (cell_in[i]),
            .dout  (cell_out[i])
        );
    end

    assign head = cell_out[0];

endmodule

/* hdl/stid_checker.sv */
`include "session_id_table_unit_defines.svh"

module stid_checker import stid_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [FUNC_W-1:0]    s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    // A held result keeps its payload
    `STID_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Any refusal or miss reports a zero id
    `STID_ASSERT(a_miss_zero_id, clk, rst_n, m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata[ID_W-1:0] == '0), "nonzero id with failing status")

    // Entry count never exceeds the table size
    `STID_ASSERT(a_count_bound, clk, rst_n, m_tvalid |-> (m_tdata[ID_W +: COUNT_OUT_W] <= COUNT_OUT_W'(CAPACITY)), "entry count above capacity")

    // One item in flight: intake closes right after an accept
    `STID_ASSERT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready |=> !s_tready, "second item taken while busy")

    // No result shown while reset is held
    `STID_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind session_id_table_unit stid_checker u_stid_checker (.*);
